FILE: rtl/flrd_pkg.sv
`timescale 1ns / 1ps
package flrd_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int IDX_W = 12;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ADDR_BYTE = 8'h03;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;

  // Command queue between parser and result generator.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PAY,
    CMD_HDR,
    CMD_CLOSE,
    CMD_BADESC
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             ovf;
    logic             bad;
    logic             last;
  } res_t;

endpackage

FILE: rtl/framed_link_receiver_destuff.sv
`timescale 1ns / 1ps
// An accepted byte is registered first in the command queue and then in the
// two-entry output queue, whose head drives the result ports.
// Throughput: one byte per cycle while full is low; an unknown escape yields two
// beats in the result generator, and the four-entry command queue absorbs that.
// Reset clears the parser to waiting for a flag, the payload position, both
// queues and expected_seq (to 0).
module framed_link_receiver_destuff (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 data_byte_o,
  output logic [flrd_pkg::IDX_W-1:0] byte_index_o,
  output logic                       overflow_o,
  output logic                       bad_escape_o,
  output logic                       last_o
);
  import flrd_pkg::*;

  logic expected_seq_q;
  logic accept;
  logic cmd_valid, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_head;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_seq_q <= 1'b0;
    end else if (cfg_we_i) begin
      expected_seq_q <= cfg_wdata_i;
    end
  end

  assign accept = push && !full;

  flrd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .expected_seq_i (expected_seq_q),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd_in)
  );

  flrd_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_head)
  );

  flrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign data_byte_o  = res.data;
  assign byte_index_o = res.idx;
  assign overflow_o   = res.ovf;
  assign bad_escape_o = res.bad;
  assign last_o       = res.last;

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_PAYLOAD || kind_o == KIND_HEADER || kind_o == KIND_CLOSE))
    else $error("undefined result kind");

  a_ctrl_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_PAYLOAD) |->
      (data_byte_o == 8'd0 && byte_index_o == '0 && !overflow_o && !bad_escape_o && last_o))
    else $error("header or close beat carries payload fields");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> byte_index_o == IDX_W'(MAX_FRAME_BYTES - 1))
    else $error("overflow without saturated index");

  a_bad_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (bad_escape_o && data_byte_o == ESC_BYTE))
    else $error("non-final beat is not the escape byte of a bad escape");

endmodule

FILE: rtl/flrd_front.sv
`timescale 1ns / 1ps
module flrd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              expected_seq_i,
  output logic              cmd_valid_o,
  output flrd_pkg::cmd_t    cmd_o
);
  import flrd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FLAG = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_CTRL = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_ESC  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [7:0] ctrl_byte, hcs_byte;

  assign ctrl_byte = {1'b0, expected_seq_i, 6'd0};
  assign hcs_byte  = ADDR_BYTE ^ ctrl_byte;

  always_comb begin
    state_d     = state_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = CMD_PAY;
    cmd_o.data  = rx_byte_i;
    case (state_q)
      ST_FLAG: begin
        if (rx_byte_i == ADDR_BYTE) begin
          state_d = ST_ADDR;
        end else if (rx_byte_i != FLAG_BYTE) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADDR: begin
        if (rx_byte_i == ctrl_byte) begin
          state_d = ST_CTRL;
        end else if (rx_byte_i == FLAG_BYTE) begin
          state_d = ST_FLAG;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CTRL: begin
        if (rx_byte_i == hcs_byte) begin
          state_d     = ST_DATA;
          cmd_valid_o = 1'b1;
          cmd_o.op    = CMD_HDR;
        end else if (rx_byte_i == FLAG_BYTE) begin
          state_d = ST_FLAG;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (rx_byte_i == ESC_BYTE) begin
          state_d = ST_ESC;
        end else if (rx_byte_i == FLAG_BYTE) begin
          state_d     = ST_IDLE;
          cmd_valid_o = 1'b1;
          cmd_o.op    = CMD_CLOSE;
        end else begin
          cmd_valid_o = 1'b1;
        end
      end
      ST_ESC: begin
        state_d     = ST_DATA;
        cmd_valid_o = 1'b1;
        if (rx_byte_i == ESC_FLAG) begin
          cmd_o.data = FLAG_BYTE;
        end else if (rx_byte_i == ESC_ESC) begin
          cmd_o.data = ESC_BYTE;
        end else begin
          cmd_o.op = CMD_BADESC;
        end
      end
      default: begin
        state_d = (rx_byte_i == FLAG_BYTE) ? ST_FLAG : ST_IDLE;
      end
    endcase
    if (!accept_i) begin
      state_d     = state_q;
      cmd_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/flrd_cmd_q.sv
`timescale 1ns / 1ps
module flrd_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  flrd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output flrd_pkg::cmd_t cmd_o
);
  import flrd_pkg::*;

  cmd_t                slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/flrd_back.sv
`timescale 1ns / 1ps
module flrd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  flrd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output flrd_pkg::res_t res_o
);
  import flrd_pkg::*;

  res_t             oq_q [2];
  logic             oq_wr_q, oq_rd_q;
  logic [1:0]       oq_cnt_q, oq_cnt_d;
  logic             oq_pop, oq_push, can_push;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             second_q, second_d;
  res_t             res;
  res_t             pay;

  assign empty_o  = (oq_cnt_q == 2'd0);
  assign res_o    = oq_q[oq_rd_q];
  assign oq_pop   = pop_i && !empty_o;
  assign can_push = (oq_cnt_q != 2'd2) || oq_pop;
  assign oq_push  = !cmd_empty_i && can_push;

  // Payload result at the current position; the position saturates at capacity.
  always_comb begin
    pay.kind = KIND_PAYLOAD;
    pay.data = cmd_i.data;
    pay.bad  = 1'b0;
    pay.last = 1'b1;
    if (cnt_q >= CNT_W'(MAX_FRAME_BYTES)) begin
      pay.idx = IDX_W'(MAX_FRAME_BYTES - 1);
      pay.ovf = 1'b1;
    end else begin
      pay.idx = IDX_W'(cnt_q);
      pay.ovf = 1'b0;
    end
  end

  always_comb begin
    res       = '0;
    res.last  = 1'b1;
    cnt_d     = cnt_q;
    second_d  = second_q;
    cmd_pop_o = 1'b0;
    if (oq_push) begin
      case (cmd_i.op)
        CMD_PAY: begin
          res       = pay;
          cmd_pop_o = 1'b1;
        end
        CMD_HDR: begin
          res.kind  = KIND_HEADER;
          cnt_d     = '0;
          cmd_pop_o = 1'b1;
        end
        CMD_CLOSE: begin
          res.kind  = KIND_CLOSE;
          cmd_pop_o = 1'b1;
        end
        CMD_BADESC: begin
          // Two beats: the escape byte first, then the unknown byte.
          res     = pay;
          res.bad = 1'b1;
          if (!second_q) begin
            res.data = ESC_BYTE;
            res.last = 1'b0;
            second_d = 1'b1;
          end else begin
            second_d  = 1'b0;
            cmd_pop_o = 1'b1;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
      if (res.kind == KIND_PAYLOAD && cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
      cnt_q    <= '0;
      second_q <= 1'b0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      cnt_q    <= cnt_d;
      second_q <= second_d;
      if (oq_push) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
    end
  end

endmodule
